// ===== rtl/core/matrix_multiply_4x4_macros.svh =====
// Assertion macros for the matrix multiplier checker.
// Depends on clk and arst_n being visible where the macros are used.
`ifndef MATRIX_MULTIPLY_4X4_MACROS_SVH
`define MATRIX_MULTIPLY_4X4_MACROS_SVH

// same-cycle implication
`define MM4_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MM4_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mm4_pkg.sv =====
// Shared types and constants of the matrix multiplier.
// No dependencies.
`timescale 1ns / 1ps

package mm4_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;
	localparam int PROD_W = 2 * DATA_W;
	localparam int IDX_W  = 2;

	localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} mm4_state_t;

	// travels alongside each read of the element stores
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last_k;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last_out;
	} mm4_tag_t;

endpackage

// ===== rtl/core/matrix_multiply_4x4.sv =====
// Top level of the DIM x DIM Q16.16 matrix multiplier.
// Depends on mm4_pkg, mm4_store, mm4_ctrl and mm4_mac.
`timescale 1ns / 1ps
//
// channel   | handshake           | words
// ----------+---------------------+---------------------------------------
// in        | start high, busy low| a_value, b_value
// out       | strobe (one cycle)  | c_value, out_row, out_col, last_out
//
// A word pair is loaded whenever start is high and busy is low. Then the
// shared multiply-accumulate unit takes one memory read pair per cycle,
// DIM*DIM*DIM pairs, one result per DIM pairs; the last result passes the
// read, product, accumulator and output registers, and busy falls after it.
// Reset clears the sequencer and the pipeline valid bits, not the stores.
// Results cannot be stalled by the receiver.

module matrix_multiply_4x4 import mm4_pkg::*; #(
	parameter int DIM = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DATA_W-1:0] a_value,
	input  logic signed [DATA_W-1:0] b_value,
	output logic                     strobe,
	output logic signed [DATA_W-1:0] c_value,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         out_col,
	output logic                     last_out
);

	localparam int CELLS = DIM * DIM;
	localparam int AW    = $clog2(CELLS);

	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr_a, rd_addr_b;
	logic [DATA_W-1:0] a_rd, b_rd;
	mm4_tag_t          tag;
	logic              drain_done;

	assign drain_done = strobe && last_out;

	mm4_ctrl #(.DIM(DIM)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.drain_done (drain_done),
		.busy       (busy),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.rd_en      (rd_en),
		.rd_addr_a  (rd_addr_a),
		.rd_addr_b  (rd_addr_b),
		.tag        (tag)
	);

	mm4_store #(.DEPTH(CELLS)) u_left (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (a_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_a),
		.rd_data (a_rd)
	);

	mm4_store #(.DEPTH(CELLS)) u_right (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (b_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_b),
		.rd_data (b_rd)
	);

	mm4_mac #(.DIM(DIM)) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag      (tag),
		.a_rd     (a_rd),
		.b_rd     (b_rd),
		.strobe   (strobe),
		.c_value  (c_value),
		.out_row  (out_row),
		.out_col  (out_col),
		.last_out (last_out)
	);

endmodule

// ===== rtl/core/mm4_store.sv =====
// Element store: one synchronous memory, one write port, one registered read port.
// Depends on mm4_pkg.
`timescale 1ns / 1ps

module mm4_store import mm4_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/mm4_ctrl.sv =====
// Sequencer: loads element pairs, then walks row, column and inner index.
// Depends on mm4_pkg.
`timescale 1ns / 1ps

module mm4_ctrl import mm4_pkg::*; #(
	parameter int DIM = 4,
	parameter int AW  = $clog2(DIM * DIM),
	parameter int RW  = $clog2(DIM)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          drain_done,
	output logic          busy,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr_a,
	output logic [AW-1:0] rd_addr_b,
	output mm4_tag_t      tag
);

	localparam logic [AW-1:0] CNT_LAST = AW'(DIM * DIM - 1);
	localparam logic [RW-1:0] IDX_LAST = RW'(DIM - 1);
	localparam logic [AW-1:0] DIM_A    = AW'(DIM);

	mm4_state_t    state_q;
	logic [AW-1:0] cnt_q;
	logic [RW-1:0] i_q, j_q, k_q;
	logic          k_end, j_end, i_end;

	assign k_end = (k_q == IDX_LAST);
	assign j_end = (j_q == IDX_LAST);
	assign i_end = (i_q == IDX_LAST);

	assign busy    = (state_q != ST_LOAD);
	assign wr_en   = start && (state_q == ST_LOAD);
	assign wr_addr = cnt_q;
	assign rd_en   = (state_q == ST_RUN);

	assign rd_addr_a = AW'(i_q) * DIM_A + AW'(k_q);
	assign rd_addr_b = AW'(k_q) * DIM_A + AW'(j_q);

	always_comb begin
		tag          = '0;
		tag.valid    = rd_en;
		tag.first    = (k_q == '0);
		tag.last_k   = k_end;
		tag.row      = IDX_W'(i_q);
		tag.col      = IDX_W'(j_q);
		tag.last_out = i_end && j_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (start) begin
						if (cnt_q == CNT_LAST) begin
							cnt_q   <= '0;
							i_q     <= '0;
							j_q     <= '0;
							k_q     <= '0;
							state_q <= ST_RUN;
						end else begin
							cnt_q <= cnt_q + AW'(1);
						end
					end
				end
				ST_RUN: begin
					if (k_end) begin
						k_q <= '0;
						if (j_end) begin
							j_q <= '0;
							if (i_end) begin
								state_q <= ST_DRAIN;
							end else begin
								i_q <= i_q + RW'(1);
							end
						end else begin
							j_q <= j_q + RW'(1);
						end
					end else begin
						k_q <= k_q + RW'(1);
					end
				end
				ST_DRAIN: begin
					if (drain_done) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/mm4_mac.sv =====
// Shared multiply-accumulate unit with rounding and saturation to Q16.16.
// Depends on mm4_pkg.
`timescale 1ns / 1ps

module mm4_mac import mm4_pkg::*; #(
	parameter int DIM   = 4,
	parameter int ACC_W = PROD_W + $clog2(DIM)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mm4_tag_t                 tag,
	input  logic [DATA_W-1:0]        a_rd,
	input  logic [DATA_W-1:0]        b_rd,
	output logic                     strobe,
	output logic signed [DATA_W-1:0] c_value,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         out_col,
	output logic                     last_out
);

	localparam int HI_LSB = DATA_W + FRAC_W - 1;
	localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_W - 1);

	mm4_tag_t                  tag_s1, tag_s2, tag_s3;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]          rnd;
	logic [ACC_W-HI_LSB-1:0]   hi;
	logic [DATA_W-1:0]         sat;
	logic                      strobe_q, last_out_q;
	logic [DATA_W-1:0]         c_value_q;
	logic [IDX_W-1:0]          out_row_q, out_col_q;

	assign rnd = acc_q + RND_HALF;
	assign hi  = rnd[ACC_W-1:HI_LSB];

	always_comb begin
		if ((&hi) || !(|hi)) begin
			sat = rnd[HI_LSB:FRAC_W];
		end else if (rnd[ACC_W-1]) begin
			sat = Q_MIN;
		end else begin
			sat = Q_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1   <= '0;
			tag_s2   <= '0;
			tag_s3   <= '0;
			strobe_q <= 1'b0;
		end else begin
			tag_s1   <= tag;
			tag_s2   <= tag_s1;
			tag_s3   <= tag_s2;
			strobe_q <= tag_s3.valid && tag_s3.last_k;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(a_rd) * $signed(b_rd);
		if (tag_s2.valid) begin
			acc_q <= tag_s2.first ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
		if (tag_s3.valid && tag_s3.last_k) begin
			c_value_q  <= sat;
			out_row_q  <= tag_s3.row;
			out_col_q  <= tag_s3.col;
			last_out_q <= tag_s3.last_out;
		end
	end

	assign strobe   = strobe_q;
	assign c_value  = $signed(c_value_q);
	assign out_row  = out_row_q;
	assign out_col  = out_col_q;
	assign last_out = last_out_q;

endmodule

// ===== rtl/core/mm4_checker.sv =====
// Port-level checker for the matrix multiplier, bound to the top level.
// Depends on mm4_pkg and matrix_multiply_4x4_macros.svh.
`timescale 1ns / 1ps
`include "matrix_multiply_4x4_macros.svh"

module mm4_checker import mm4_pkg::*; #(
	parameter int DIM = 4
) (
	input logic             clk,
	input logic             arst_n,
	input logic             busy,
	input logic             strobe,
	input logic [IDX_W-1:0] out_row,
	input logic [IDX_W-1:0] out_col,
	input logic             last_out
);

	`MM4_ASSERT_NOW(a_strobe_busy, strobe, busy, "result word outside a busy period")
	`MM4_ASSERT_NEXT(a_last_gap, strobe && last_out, !strobe, "result word after the final one")
	`MM4_ASSERT_NOW(a_last_pos, strobe && last_out, (out_row == IDX_W'(DIM - 1)) && (out_col == IDX_W'(DIM - 1)), "final word at wrong position")
	`MM4_ASSERT_NOW(a_busy_end, $fell(busy), $past(strobe && last_out), "busy dropped before the final word")

endmodule

bind matrix_multiply_4x4 mm4_checker #(.DIM(DIM)) u_mm4_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.busy     (busy),
	.strobe   (strobe),
	.out_row  (out_row),
	.out_col  (out_col),
	.last_out (last_out)
);
